// ----- rtl/core/icymd_pkg.sv -----
package icymd_pkg;

    // Kind of each outgoing word
    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_AUDIO    = 2'd1,
        KIND_META_LEN = 2'd2,
        KIND_META     = 2'd3
    } byte_kind_t;

    // Progress of the metaint key and its value
    typedef enum logic [1:0] {
        KEY_SEARCH  = 2'd0,
        KEY_VALUE   = 2'd1,
        KEY_DONE    = 2'd2,
        KEY_INVALID = 2'd3
    } key_status_t;

    localparam logic [3:0] KEY_LEN       = 4'd12;
    localparam logic [3:0] KEY_RESTART_K = 4'd9;
    localparam logic [3:0] KEY_AFTER_IC  = 4'd2;
    localparam logic [7:0] CHAR_CR       = 8'h0d;
    localparam logic [7:0] CHAR_LF       = 8'h0a;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_C  = 8'h63;
    localparam logic [7:0] CHAR_LOWER_I  = 8'h69;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam int         META_LEN_BITS = 12;

    // Lowercase text of "icy-metaint:"
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                4'd0:    ch = 8'h69; // i
                4'd1:    ch = 8'h63; // c
                4'd2:    ch = 8'h79; // y
                4'd3:    ch = 8'h2d; // -
                4'd4:    ch = 8'h6d; // m
                4'd5:    ch = 8'h65; // e
                4'd6:    ch = 8'h74; // t
                4'd7:    ch = 8'h61; // a
                4'd8:    ch = 8'h69; // i
                4'd9:    ch = 8'h6e; // n
                4'd10:   ch = 8'h74; // t
                4'd11:   ch = 8'h3a; // :
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// ----- rtl/core/icy_stream_metadata_demux.sv -----
// ICY stream metadata demux. Takes one received stream word per cycle while
// in_ready is high and returns it tagged as header, audio, metadata length or
// metadata. During the header it scans for the blank line (CR LF CR LF) and
// parses the first "icy-metaint:" value (case-insensitive, spaces skipped, bad
// characters give 0, saturating at INTERVAL_BITS). Each word is held in the
// input register, where the parser state is updated, and then sits in the
// output register; with both sides flowing a word is accepted every cycle.
// The metadata length word is scaled by 16. A connection_start word restarts
// header parsing; metadata_enable is kept.
// Write metadata_enable only while no words are in flight.
module icy_stream_metadata_demux #(
    parameter int INTERVAL_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       connection_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] byte_kind,
    output logic       metadata_last,
    output logic       header_done,
    output logic       no_metadata
);
    import icymd_pkg::*;

    localparam int WIDE_BITS = INTERVAL_BITS + 4;

    // Configuration
    logic metadata_enable_reg;

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       advance;

    // Parser state
    logic                         in_header_reg, in_header_next;
    logic [1:0]                   end_count_reg, end_count_next;
    logic [3:0]                   key_count_reg, key_count_next;
    key_status_t                  key_status_reg, key_status_next;
    logic [INTERVAL_BITS-1:0]     interval_reg, interval_next;
    logic [INTERVAL_BITS-1:0]     audio_count_reg, audio_count_next;
    logic [META_LEN_BITS-1:0]     meta_rem_reg, meta_rem_next;

    // Result
    logic       out_valid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    byte_kind_t kind_reg, kind_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic       nometa_reg, nometa_next;

    // Handshake: input stage moves on whenever the output slot is free
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metadata_enable_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            metadata_enable_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= data_byte;
            s1_start_reg <= connection_start;
        end
    end

    // Parse and classify one word
    always_comb
    begin
        logic                     cur_in_header;
        logic [1:0]               cur_end;
        logic [3:0]               cur_key;
        key_status_t              cur_status;
        logic [INTERVAL_BITS-1:0] cur_interval;
        logic [INTERVAL_BITS-1:0] cur_audio;
        logic [META_LEN_BITS-1:0] cur_rem;
        logic                     meta_on;
        logic [7:0]               b;
        logic [7:0]               lc;
        logic [3:0]               k;
        logic [7:0]               end_ch;
        logic [WIDE_BITS-1:0]     wide_val;
        logic [WIDE_BITS-1:0]     digit;

        b = s1_byte_reg;

        // Connection restart clears stream state before this word
        cur_in_header = s1_start_reg ? 1'b1 : in_header_reg;
        cur_end       = s1_start_reg ? 2'd0 : end_count_reg;
        cur_key       = s1_start_reg ? 4'd0 : key_count_reg;
        cur_status    = s1_start_reg ? KEY_SEARCH : key_status_reg;
        cur_interval  = s1_start_reg ? '0 : interval_reg;
        cur_audio     = s1_start_reg ? '0 : audio_count_reg;
        cur_rem       = s1_start_reg ? '0 : meta_rem_reg;

        meta_on = metadata_enable_reg && (cur_interval != '0);

        in_header_next   = cur_in_header;
        end_count_next   = cur_end;
        key_count_next   = cur_key;
        key_status_next  = cur_status;
        interval_next    = cur_interval;
        audio_count_next = cur_audio;
        meta_rem_next    = cur_rem;

        out_byte_next = b;
        kind_next     = KIND_HEADER;
        last_next     = 1'b0;
        done_next     = 1'b0;
        nometa_next   = 1'b0;

        lc = ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ? b + CASE_OFFSET : b;
        k  = cur_key;
        digit    = WIDE_BITS'(b - CHAR_ZERO);
        wide_val = (WIDE_BITS'(cur_interval) << 3) + (WIDE_BITS'(cur_interval) << 1)
                   + digit;
        end_ch   = cur_end[0] ? CHAR_LF : CHAR_CR;

        if (cur_in_header)
        begin
            // Key matcher and value parser
            case (cur_status)
                KEY_SEARCH:
                begin
                    if ((k < KEY_LEN) && (lc == key_char(k)))
                    begin
                        k = k + 4'd1;
                    end
                    else if ((k == KEY_RESTART_K) && (lc == CHAR_LOWER_C))
                    begin
                        k = KEY_AFTER_IC;
                    end
                    else if (lc == CHAR_LOWER_I)
                    begin
                        k = 4'd1;
                    end
                    else
                    begin
                        k = 4'd0;
                    end
                    if (k >= KEY_LEN)
                    begin
                        key_status_next = KEY_VALUE;
                        k = 4'd0;
                    end
                    key_count_next = k;
                end
                KEY_VALUE:
                begin
                    if (b == CHAR_CR)
                    begin
                        key_status_next = KEY_DONE;
                    end
                    else if (b == CHAR_SPACE)
                    begin
                        key_status_next = KEY_VALUE;
                    end
                    else if ((b >= CHAR_ZERO) && (b <= CHAR_NINE))
                    begin
                        // saturate on overflow
                        if (wide_val[WIDE_BITS-1:INTERVAL_BITS] != '0)
                            interval_next = '1;
                        else
                            interval_next = wide_val[INTERVAL_BITS-1:0];
                    end
                    else
                    begin
                        interval_next   = '0;
                        key_status_next = KEY_INVALID;
                    end
                end
                default:
                begin
                    key_status_next = cur_status;
                end
            endcase

            // Blank-line detector
            if (b == end_ch)
            begin
                if (cur_end == 2'd3)
                begin
                    end_count_next = 2'd0;
                    in_header_next = 1'b0;
                    done_next      = 1'b1;
                    nometa_next    = metadata_enable_reg && (cur_interval == '0);
                end
                else
                begin
                    end_count_next = cur_end + 2'd1;
                end
            end
            else
            begin
                end_count_next = (b == CHAR_CR) ? 2'd1 : 2'd0;
            end
        end
        else if (meta_on && (cur_audio == cur_interval))
        begin
            kind_next        = KIND_META_LEN;
            audio_count_next = '0;
            meta_rem_next    = {b, 4'b0000};
        end
        else if (cur_rem != '0)
        begin
            kind_next     = KIND_META;
            meta_rem_next = cur_rem - META_LEN_BITS'(1);
            last_next     = (cur_rem == META_LEN_BITS'(1));
        end
        else
        begin
            kind_next = KIND_AUDIO;
            if (meta_on)
                audio_count_next = cur_audio + INTERVAL_BITS'(1);
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg   <= 1'b1;
            end_count_reg   <= 2'd0;
            key_count_reg   <= 4'd0;
            key_status_reg  <= KEY_SEARCH;
            interval_reg    <= '0;
            audio_count_reg <= '0;
            meta_rem_reg    <= '0;
        end
        else if (advance)
        begin
            in_header_reg   <= in_header_next;
            end_count_reg   <= end_count_next;
            key_count_reg   <= key_count_next;
            key_status_reg  <= key_status_next;
            interval_reg    <= interval_next;
            audio_count_reg <= audio_count_next;
            meta_rem_reg    <= meta_rem_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= out_byte_next;
            kind_reg     <= kind_next;
            last_reg     <= last_next;
            done_reg     <= done_next;
            nometa_reg   <= nometa_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_kind     = kind_reg;
    assign metadata_last = last_reg;
    assign header_done   = done_reg;
    assign no_metadata   = nometa_reg;

`ifndef SYNTHESIS
    // no_metadata only accompanies the end of the header
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_metadata) |-> header_done)
        else $error("no_metadata without header_done");

    // last flag only on a metadata word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && metadata_last) |-> (byte_kind == KIND_META))
        else $error("metadata_last on non-metadata word");

    // header end is reported on a header word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && header_done) |-> (byte_kind == KIND_HEADER))
        else $error("header_done on non-header word");

    // an empty input stage always takes a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled while empty");

    // once the header ends, no header word until a restart
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_start_reg && !in_header_reg) |=> (kind_reg != KIND_HEADER))
        else $error("header word after header end");
`endif

endmodule
